/* src/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types, constants and character classification for the base64 decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int unsigned GroupBytes = 3;

	localparam logic [5:0] SextetLowerBase = 6'd26;
	localparam logic [5:0] SextetDigitBase = 6'd52;
	localparam logic [5:0] SextetPlus      = 6'd62;
	localparam logic [5:0] SextetSlash     = 6'd63;
	localparam logic [5:0] LowNibbleMask   = 6'h0F;
	localparam logic [5:0] LowPairMask     = 6'h03;

	localparam logic [7:0] CharPad = 8'h3D;

	typedef struct packed {
		logic [5:0] sextet;
		logic       pad;
		logic       bad;
	} b64d_class_t;

	typedef struct packed {
		logic [GroupBytes-1:0][7:0] bytes;
		logic [1:0]                 count;
	} b64d_group_t;

	function automatic logic b64d_is_blank(input logic [7:0] c);
		logic r;
		r = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
			(c == 8'h0C) || (c == 8'h0B);
		return r;
	endfunction

	function automatic b64d_class_t b64d_classify(input logic [7:0] c);
		b64d_class_t r;
		logic [7:0]  d;
		r = '{sextet: 6'd0, pad: 1'b0, bad: 1'b0};
		d = 8'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			d = c - 8'h41;
			r.sextet = d[5:0];
		end else if (c inside {[8'h61:8'h7A]}) begin
			d = c - 8'h61;
			r.sextet = d[5:0] + SextetLowerBase;
		end else if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30;
			r.sextet = d[5:0] + SextetDigitBase;
		end else if (c == 8'h2B) begin
			r.sextet = SextetPlus;
		end else if (c == 8'h2F) begin
			r.sextet = SextetSlash;
		end else if (c == CharPad) begin
			r.pad = 1'b1;
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

/* src/b64d_group.sv */
// ----------------------------------------------------------------------------
// b64d_group
// collects sextets into groups of four and assembles the decoded bytes
// ----------------------------------------------------------------------------
module b64d_group (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            char_code,
	input  logic                  end_of_message,
	output logic                  group_full,
	output logic                  load,
	output b64d_pkg::b64d_group_t result
);
	import b64d_pkg::*;

	logic [1:0]  fill_q;
	logic [5:0]  held_q [GroupBytes];
	logic [2:0]  pad_q;
	logic        inv_q;

	b64d_class_t cls;
	logic        blank;
	logic [3:0]  marks;

	always_comb begin
		cls   = b64d_classify(char_code);
		blank = b64d_is_blank(char_code);
		marks = {cls.pad, pad_q};
		result.bytes[0] = {held_q[0], held_q[1][5:4]};
		result.bytes[1] = {held_q[1][3:0] & LowNibbleMask[3:0], held_q[2][5:2]};
		result.bytes[2] = {held_q[2][1:0] & LowPairMask[1:0], cls.sextet};
		result.count    = 2'd0;
		if (!(inv_q || cls.bad)) begin
			case (marks)
				4'b0000: result.count = 2'd3;
				4'b1000: result.count = 2'd2;
				4'b1100: result.count = 2'd1;
				default: result.count = 2'd0;
			endcase
		end
	end

	assign group_full = (fill_q == 2'd3);
	assign load       = accept && !blank && group_full && (result.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
			pad_q  <= 3'd0;
			inv_q  <= 1'b0;
			for (int i = 0; i < GroupBytes; i++) held_q[i] <= 6'd0;
		end else if (accept) begin
			if (end_of_message || (!blank && group_full)) begin
				fill_q <= 2'd0;
				pad_q  <= 3'd0;
				inv_q  <= 1'b0;
				for (int i = 0; i < GroupBytes; i++) held_q[i] <= 6'd0;
			end else if (!blank) begin
				for (int i = 0; i < GroupBytes; i++) begin
					if (fill_q == 2'(i)) begin
						held_q[i] <= cls.sextet;
						pad_q[i]  <= cls.pad;
					end
				end
				if (cls.bad) inv_q <= 1'b1;
				fill_q <= fill_q + 2'd1;
			end
		end
	end

endmodule

/* src/b64d_out_buf.sv */
// ----------------------------------------------------------------------------
// b64d_out_buf
// result register holding one decoded group, drained one byte per transfer
// ----------------------------------------------------------------------------
module b64d_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  b64d_pkg::b64d_group_t result,
	output logic                  empty,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tlast
);
	import b64d_pkg::*;

	logic [1:0] count_q;
	logic [7:0] bytes_q [GroupBytes];
	logic       pop;

	assign empty    = (count_q == 2'd0);
	assign m_tvalid = !empty;
	assign m_tdata  = bytes_q[0];
	assign m_tlast  = (count_q == 2'd1);
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (load) begin
			count_q <= result.count;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < GroupBytes; i++) bytes_q[i] <= result.bytes[i];
		end else if (pop) begin
			for (int i = 0; i < GroupBytes - 1; i++) bytes_q[i] <= bytes_q[i+1];
		end
	end

endmodule

/* src/base64_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// streaming base64 decoder, one character in per transfer, bytes out per group
// ----------------------------------------------------------------------------
// first byte of a group is valid the cycle after its fourth character
// 1 character per cycle if s_tready; bytes leave 1 per cycle if m_tready from
//   the result register, which must be empty before the next group completes
// reset: arst_n clears the group state and empties the result register
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // char_code[7:0]
	input  logic       s_tlast,   // end_of_message
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // data_byte[7:0]
	output logic       m_tlast    // last
);
	import b64d_pkg::*;

	logic        accept;
	logic        group_full;
	logic        load;
	logic        empty;
	b64d_group_t result;

	assign s_tready = !group_full || empty;
	assign accept   = s_tvalid && s_tready;

	b64d_group u_group (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.char_code      (s_tdata),
		.end_of_message (s_tlast),
		.group_full     (group_full),
		.load           (load),
		.result         (result)
	);

	b64d_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.result   (result),
		.empty    (empty),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
